FILE: rtl/assert_macros.svh
// Assertion macros shared by the linked list engine RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and an active-low reset.
`define ALLE_ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion on the module's own i_clk and i_rst_n.
`define ALLE_ASSERT(label, prop, msg) \
    `ALLE_ASSERT_ON(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: rtl/alle_pkg.sv
// Types and constants shared by the linked list engine modules.
// Depends on nothing.
`default_nettype none

package alle_pkg;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ_ALL  = 3'd4;

    typedef enum logic [1:0] {
        K_INS,
        K_DEL,
        K_READ,
        K_BAD
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_START,
        OP_STEP,
        OP_INS_HEAD,
        OP_INS_LINK,
        OP_INS_PREV,
        OP_DEL_HEAD,
        OP_DEL_SEEK,
        OP_DEL_FIX,
        OP_SCAN,
        OP_EMIT_DATA,
        OP_EMIT_RESULT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ok;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  pre_ok;
        logic  p_zero;
        logic  cnt_zero;
        logic  left_zero;
        logic  last;
        logic  scan_done;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/array_linked_list_engine.sv
// Linked list engine: a singly linked list kept in a fixed pool of nodes.
// The input channel takes one operation per item (func, position, value_in)
// and is stalled while an operation is in progress; it is free again as soon
// as the last result has been loaded into the output register, even if the
// receiver has not yet taken it. The output channel carries one result per
// operation, or one per list element for read all, with last_of_run on the
// final one. Each link hop waits on the link RAM's registered read, so a walk
// alternates a wait state and a step state: insert or delete at position p
// scales with p, push and pop at the back scale with the list length, read
// all waits on the read for each element, and every insert adds a free-slot
// scan through the pool. A refused operation goes from decode to the result.
// A stalled result holds the output register and the engine waits on it.
// Synchronous reset leaves the list empty and all nodes free; node data and
// links are not cleared and need no clearing pass.
// Depends on alle_pkg, alle_ctrl, alle_dp, alle_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module array_linked_list_engine #(
    parameter int POOL_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [alle_pkg::FUNC_W-1:0]         i_func,
    input  wire logic [alle_pkg::POS_W-1:0]          i_position,
    input  wire logic signed [alle_pkg::VALUE_W-1:0] i_value_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_success,
    output logic signed [alle_pkg::VALUE_W-1:0]      o_value_out,
    output logic                                     o_value_valid,
    output logic                                     o_last_of_run,
    output logic      [alle_pkg::COUNT_W-1:0]        o_element_count
);

    alle_pkg::t_cmd  cmd;
    alle_pkg::t_stat stat;
    logic            idle;

    alle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    alle_dp #(
        .POOL_DEPTH (POOL_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (i_func),
        .i_position      (i_position),
        .i_value_in      (i_value_in),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_success       (o_success),
        .o_value_out     (o_value_out),
        .o_value_valid   (o_value_valid),
        .o_last_of_run   (o_last_of_run),
        .o_element_count (o_element_count)
    );

    assign o_in_stall = !idle;

    `ALLE_ASSERT(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall, "engine took a second item while busy")
    `ALLE_ASSERT(a_element_is_success, (o_out_valid && o_value_valid) |-> o_success, "list element reported without success")
    `ALLE_ASSERT(a_status_result_form, (o_out_valid && !o_value_valid) |-> (o_last_of_run && o_value_out == 0), "status result is not a zero final item")

endmodule

`default_nettype wire

FILE: rtl/alle_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/alle_ctrl.sv
// Controller state machine of the linked list engine.
// Depends on alle_pkg for the command and status types.
`default_nettype none

module alle_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire alle_pkg::t_stat i_stat,
    output alle_pkg::t_cmd      o_cmd,
    output logic                o_idle
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK_WAIT,
        ST_WALK,
        ST_INS_PREV,
        ST_DEL_WAIT,
        ST_DEL_FIX,
        ST_SCAN,
        ST_RA_WAIT,
        ST_RA_EMIT,
        ST_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ok;
    logic   n_ok;

    always_comb begin
        n_state    = r_state;
        n_ok       = r_ok;
        o_cmd.op   = alle_pkg::OP_NONE;
        o_cmd.ok   = r_ok;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = alle_pkg::OP_LATCH;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_ok = 1'b1;
                if (!i_stat.pre_ok) begin
                    n_ok    = 1'b0;
                    n_state = ST_RESULT;
                end else if (i_stat.kind == alle_pkg::K_INS && i_stat.p_zero) begin
                    o_cmd.op = alle_pkg::OP_INS_HEAD;
                    n_state  = ST_SCAN;
                end else if (i_stat.kind == alle_pkg::K_READ) begin
                    if (i_stat.cnt_zero) begin
                        n_state = ST_RESULT;
                    end else begin
                        o_cmd.op = alle_pkg::OP_START;
                        n_state  = ST_RA_WAIT;
                    end
                end else begin
                    o_cmd.op = alle_pkg::OP_START;
                    n_state  = ST_WALK_WAIT;
                end
            end
            ST_WALK_WAIT: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!i_stat.left_zero) begin
                    o_cmd.op = alle_pkg::OP_STEP;
                    n_state  = ST_WALK_WAIT;
                end else if (i_stat.kind == alle_pkg::K_INS) begin
                    o_cmd.op = alle_pkg::OP_INS_LINK;
                    n_state  = ST_INS_PREV;
                end else if (i_stat.p_zero) begin
                    o_cmd.op = alle_pkg::OP_DEL_HEAD;
                    n_state  = ST_RESULT;
                end else begin
                    o_cmd.op = alle_pkg::OP_DEL_SEEK;
                    n_state  = ST_DEL_WAIT;
                end
            end
            ST_INS_PREV: begin
                o_cmd.op = alle_pkg::OP_INS_PREV;
                n_state  = ST_SCAN;
            end
            ST_DEL_WAIT: begin
                n_state = ST_DEL_FIX;
            end
            ST_DEL_FIX: begin
                o_cmd.op = alle_pkg::OP_DEL_FIX;
                n_state  = ST_RESULT;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.op = alle_pkg::OP_SCAN;
                end
            end
            ST_RA_WAIT: begin
                n_state = ST_RA_EMIT;
            end
            ST_RA_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = alle_pkg::OP_EMIT_DATA;
                    n_state  = i_stat.last ? ST_IDLE : ST_RA_WAIT;
                end
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = alle_pkg::OP_EMIT_RESULT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/alle_dp.sv
// Datapath of the linked list engine: node pool RAMs, list registers, output register.
// Depends on alle_pkg and alle_ram.
`default_nettype none

module alle_dp #(
    parameter int POOL_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire alle_pkg::t_cmd                      i_cmd,
    output alle_pkg::t_stat                          o_stat,
    input  wire logic [alle_pkg::FUNC_W-1:0]         i_func,
    input  wire logic [alle_pkg::POS_W-1:0]          i_position,
    input  wire logic signed [alle_pkg::VALUE_W-1:0] i_value_in,
    input  wire logic                                i_out_stall,
    output logic                                     o_out_valid,
    output logic                                     o_success,
    output logic signed [alle_pkg::VALUE_W-1:0]      o_value_out,
    output logic                                     o_value_valid,
    output logic                                     o_last_of_run,
    output logic      [alle_pkg::COUNT_W-1:0]        o_element_count
);

    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int PW = (LW > alle_pkg::POS_W) ? LW : alle_pkg::POS_W;
    localparam logic [LW-1:0] NULL_IDX = LW'(POOL_DEPTH);

    logic [alle_pkg::FUNC_W-1:0]  r_func,  n_func;
    logic [alle_pkg::POS_W-1:0]   r_pos,   n_pos;
    logic [DATA_WIDTH-1:0]        r_val,   n_val;
    logic [LW-1:0]                r_head,  n_head;
    logic [LW-1:0]                r_count, n_count;
    logic [POOL_DEPTH-1:0]        r_used,  n_used;
    logic [LW-1:0]                r_free,  n_free;
    logic [LW-1:0]                r_at,    n_at;
    logic [LW-1:0]                r_prev,  n_prev;
    logic [PW-1:0]                r_left,  n_left;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_success, n_out_success;
    logic [alle_pkg::VALUE_W-1:0] r_out_value, n_out_value;
    logic                         r_out_vvalid, n_out_vvalid;
    logic                         r_out_last, n_out_last;
    logic [alle_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    logic                  link_we;
    logic [AW-1:0]         link_waddr;
    logic [LW-1:0]         link_wdata;
    logic [LW-1:0]         link_rdata;
    logic                  val_we;
    logic [DATA_WIDTH-1:0] val_rdata;

    alle_pkg::t_kind kind;
    logic [PW-1:0]   p_sel;
    logic [PW-1:0]   cnt_ext;
    logic [PW-1:0]   left_init;
    logic            p_zero;
    logic            ins_ok;
    logic            del_ok;
    logic            pre_ok;
    logic            last;
    logic            scan_done;
    logic            out_free;
    logic [LW-1:0]   free_min;

    alle_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (r_at[AW-1:0]),
        .o_rdata (link_rdata)
    );

    alle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (POOL_DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_free[AW-1:0]),
        .i_wdata (r_val),
        .i_raddr (r_at[AW-1:0]),
        .o_rdata (val_rdata)
    );

    always_comb begin
        cnt_ext = PW'(r_count);
        case (r_func)
            alle_pkg::FUNC_INSERT: begin
                kind  = alle_pkg::K_INS;
                p_sel = PW'(r_pos);
            end
            alle_pkg::FUNC_PUSH_BACK: begin
                kind  = alle_pkg::K_INS;
                p_sel = cnt_ext;
            end
            alle_pkg::FUNC_POP_BACK: begin
                kind  = alle_pkg::K_DEL;
                p_sel = cnt_ext - PW'(1);
            end
            alle_pkg::FUNC_DELETE: begin
                kind  = alle_pkg::K_DEL;
                p_sel = PW'(r_pos);
            end
            alle_pkg::FUNC_READ_ALL: begin
                kind  = alle_pkg::K_READ;
                p_sel = '0;
            end
            default: begin
                kind  = alle_pkg::K_BAD;
                p_sel = '0;
            end
        endcase

        p_zero = (p_sel == '0);
        ins_ok = (p_sel <= cnt_ext) && (r_count < NULL_IDX) && (r_free != NULL_IDX);
        del_ok = (r_count != '0) && (p_sel < cnt_ext);
        case (kind)
            alle_pkg::K_INS:  pre_ok = ins_ok;
            alle_pkg::K_DEL:  pre_ok = del_ok;
            alle_pkg::K_READ: pre_ok = 1'b1;
            default:          pre_ok = 1'b0;
        endcase

        if (kind == alle_pkg::K_READ) begin
            left_init = cnt_ext - PW'(1);
        end else if (p_zero) begin
            left_init = '0;
        end else begin
            left_init = p_sel - PW'(1);
        end

        last      = (r_left == '0) || (link_rdata == NULL_IDX);
        scan_done = (r_free == NULL_IDX) || !r_used[r_free[AW-1:0]];
        out_free  = !r_out_valid || !i_out_stall;
        free_min  = (r_at < r_free) ? r_at : r_free;
    end

    always_comb begin
        o_stat.kind      = kind;
        o_stat.pre_ok    = pre_ok;
        o_stat.p_zero    = p_zero;
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.left_zero = (r_left == '0);
        o_stat.last      = last;
        o_stat.scan_done = scan_done;
        o_stat.out_free  = out_free;
    end

    always_comb begin
        n_func        = r_func;
        n_pos         = r_pos;
        n_val         = r_val;
        n_head        = r_head;
        n_count       = r_count;
        n_used        = r_used;
        n_free        = r_free;
        n_at          = r_at;
        n_prev        = r_prev;
        n_left        = r_left;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_success = r_out_success;
        n_out_value   = r_out_value;
        n_out_vvalid  = r_out_vvalid;
        n_out_last    = r_out_last;
        n_out_count   = r_out_count;
        link_we       = 1'b0;
        link_waddr    = r_free[AW-1:0];
        link_wdata    = r_head;
        val_we        = 1'b0;

        case (i_cmd.op)
            alle_pkg::OP_LATCH: begin
                n_func = i_func;
                n_pos  = i_position;
                n_val  = DATA_WIDTH'($unsigned(i_value_in));
            end
            alle_pkg::OP_START: begin
                n_at   = r_head;
                n_left = left_init;
            end
            alle_pkg::OP_STEP: begin
                n_at   = link_rdata;
                n_left = r_left - PW'(1);
            end
            alle_pkg::OP_INS_HEAD: begin
                link_we                = 1'b1;
                val_we                 = 1'b1;
                n_head                 = r_free;
                n_used[r_free[AW-1:0]] = 1'b1;
                n_count                = r_count + LW'(1);
            end
            alle_pkg::OP_INS_LINK: begin
                link_we                = 1'b1;
                link_wdata             = link_rdata;
                val_we                 = 1'b1;
                n_used[r_free[AW-1:0]] = 1'b1;
                n_count                = r_count + LW'(1);
            end
            alle_pkg::OP_INS_PREV: begin
                link_we    = 1'b1;
                link_waddr = r_at[AW-1:0];
                link_wdata = r_free;
            end
            alle_pkg::OP_DEL_HEAD: begin
                n_head               = link_rdata;
                n_used[r_at[AW-1:0]] = 1'b0;
                n_count              = r_count - LW'(1);
                n_free               = free_min;
            end
            alle_pkg::OP_DEL_SEEK: begin
                n_prev = r_at;
                n_at   = link_rdata;
            end
            alle_pkg::OP_DEL_FIX: begin
                link_we              = 1'b1;
                link_waddr           = r_prev[AW-1:0];
                link_wdata           = link_rdata;
                n_used[r_at[AW-1:0]] = 1'b0;
                n_count              = r_count - LW'(1);
                n_free               = free_min;
            end
            alle_pkg::OP_SCAN: begin
                n_free = r_free + LW'(1);
            end
            alle_pkg::OP_EMIT_DATA: begin
                n_out_valid   = 1'b1;
                n_out_success = 1'b1;
                n_out_value   = alle_pkg::VALUE_W'(val_rdata);
                n_out_vvalid  = 1'b1;
                n_out_last    = last;
                n_out_count   = alle_pkg::COUNT_W'(r_count);
                n_at          = link_rdata;
                n_left        = r_left - PW'(1);
            end
            alle_pkg::OP_EMIT_RESULT: begin
                n_out_valid   = 1'b1;
                n_out_success = i_cmd.ok;
                n_out_value   = '0;
                n_out_vvalid  = 1'b0;
                n_out_last    = 1'b1;
                n_out_count   = alle_pkg::COUNT_W'(r_count);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NULL_IDX;
            r_count     <= '0;
            r_used      <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_used      <= n_used;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_pos         <= n_pos;
        r_val         <= n_val;
        r_at          <= n_at;
        r_prev        <= n_prev;
        r_left        <= n_left;
        r_out_success <= n_out_success;
        r_out_value   <= n_out_value;
        r_out_vvalid  <= n_out_vvalid;
        r_out_last    <= n_out_last;
        r_out_count   <= n_out_count;
    end

    assign o_out_valid     = r_out_valid;
    assign o_success       = r_out_success;
    assign o_value_out     = r_out_value;
    assign o_value_valid   = r_out_vvalid;
    assign o_last_of_run   = r_out_last;
    assign o_element_count = r_out_count;

endmodule

`default_nettype wire
